// ----- rtl/core/bblc_pkg.sv -----
package bblc_pkg;

    // fixed field widths
    localparam int KEY_W    = 16;
    localparam int SIZE_W   = 28;
    localparam int BUDGET_W = 34;
    localparam int KIND_W   = 2;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 34'd268435456;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_EVICT  = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_MISS   = 2'd2,
        KIND_INSERT = 2'd3
    } t_kind;

    // request commands
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // control sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_HIT,
        S_MISS,
        S_SHIFT,
        S_SH_END,
        S_EV_CHK,
        S_EV_OUT,
        S_INSERT
    } t_state;

endpackage

// ----- rtl/core/bblc_req_if.sv -----
interface bblc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [bblc_pkg::KEY_W-1:0]    key;
    logic [bblc_pkg::SIZE_W-1:0]   size;

    modport source (output valid, command, key, size, input ready);
    modport sink   (input valid, command, key, size, output ready);
endinterface

// ----- rtl/core/bblc_rsp_if.sv -----
interface bblc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bblc_pkg::KIND_W-1:0]     kind;
    logic [bblc_pkg::KEY_W-1:0]      entry_key;
    logic [bblc_pkg::SIZE_W-1:0]     entry_size;
    logic [bblc_pkg::BUDGET_W-1:0]   used_bytes;
    logic                            last;

    modport source (output valid, kind, entry_key, entry_size, used_bytes, last, input ready);
    modport sink   (input valid, kind, entry_key, entry_size, used_bytes, last, output ready);
endinterface

// ----- rtl/core/bblc_cfg_if.sv -----
interface bblc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bblc_pkg::BUDGET_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/bblc_dir_ram.sv -----
// directory store kept as a ring: logical position 0 is the least recent entry,
// the physical row is the head pointer plus the logical position, wrapped
module bblc_dir_ram #(
    parameter int ENTRIES = 32,
    parameter int WIDTH   = 44,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_head,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_pos,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_pos,
    input  logic [WIDTH-1:0] i_wr_data
);

    localparam logic [IDX_W:0] DEPTH = (IDX_W+1)'(ENTRIES);

    logic [WIDTH-1:0] mem [ENTRIES];
    logic [IDX_W:0]   rd_sum;
    logic [IDX_W:0]   wr_sum;
    logic [IDX_W:0]   rd_row_w;
    logic [IDX_W:0]   wr_row_w;
    logic [IDX_W-1:0] rd_row;
    logic [IDX_W-1:0] wr_row;

    // logical to physical row, one wrap at most
    always_comb begin
        rd_sum   = {1'b0, i_head} + {1'b0, i_rd_pos};
        wr_sum   = {1'b0, i_head} + {1'b0, i_wr_pos};
        rd_row_w = (rd_sum >= DEPTH) ? rd_sum - DEPTH : rd_sum;
        wr_row_w = (wr_sum >= DEPTH) ? wr_sum - DEPTH : wr_sum;
        rd_row   = rd_row_w[IDX_W-1:0];
        wr_row   = wr_row_w[IDX_W-1:0];
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[wr_row] <= i_wr_data;
        end
    end

    // registered read port, holds its data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[rd_row];
        end
    end

endmodule

// ----- rtl/core/byte_budget_lru_cache_core.sv -----
// channel  | dir | beat carries                                    | handshake
// i_req    | in  | command, key, size                              | valid/ready
// o_rsp    | out | kind, entry_key, entry_size, used_bytes, last   | valid/ready
// i_cfg    | in  | data (budget_bytes)                             | valid/ready, always ready
//
// one request at a time; the single read port of the directory ring sets the pace.
// lookup: key search one entry a cycle, then the entries behind a hit move down
// one a cycle. insert: key search; where a same-key entry is found, the entries
// behind it move down and it is removed; then each eviction is checked and given
// out in turn, then a last check and the new entry is placed.
// reset is synchronous, no clearing pass: the fill count marks which rows hold data.
// a stalled o_rsp holds one result in its register; the sequencer waits only
// where it has a further result to give.
module byte_budget_lru_cache_core #(
    parameter int ENTRIES  = 32,
    parameter int KEY_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bblc_req_if.sink       i_req,
    bblc_rsp_if.source     o_rsp,
    bblc_cfg_if.sink       i_cfg
);

    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SIZE_W  = bblc_pkg::SIZE_W;
    localparam int BUD_W   = bblc_pkg::BUDGET_W;
    localparam int KEY_W   = bblc_pkg::KEY_W;
    localparam int EXT_W   = KEY_BITS + KEY_W;
    localparam int ENT_W   = KEY_BITS + SIZE_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    bblc_pkg::t_state r_state, n_state;

    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [SIZE_W-1:0]   r_size;
    logic [BUD_W-1:0]    r_budget;
    logic [BUD_W-1:0]    r_total;
    logic [CNT_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_pos;
    logic                r_chk_valid;
    logic [CNT_W-1:0]    r_chk_pos;
    logic                r_pend;
    logic [IDX_W-1:0]    r_wr_pos;
    logic [KEY_BITS-1:0] r_ent_key;
    logic [SIZE_W-1:0]   r_ent_size;

    logic                r_out_valid;
    bblc_pkg::t_kind     r_out_kind;
    logic [KEY_W-1:0]    r_out_key;
    logic [SIZE_W-1:0]   r_out_size;
    logic [BUD_W-1:0]    r_out_used;
    logic                r_out_last;

    // directory port
    logic                rd_en;
    logic [IDX_W-1:0]    rd_pos;
    logic [ENT_W-1:0]    rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_pos;
    logic [ENT_W-1:0]    wr_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [SIZE_W-1:0]   rd_size;

    // sequencer helpers
    logic                in_acc;
    logic                can_emit;
    logic                more_rd;
    logic                found;
    logic                over_budget;
    logic                ev_need;
    logic [EXT_W-1:0]    in_key_ext;
    logic [KEY_BITS-1:0] in_key;
    logic [BUD_W:0]      need_sum;
    logic [IDX_W-1:0]    head_next;

    // sequencer outputs
    logic                emit;
    bblc_pkg::t_kind     emit_kind;
    logic [KEY_BITS-1:0] emit_key;
    logic [SIZE_W-1:0]   emit_size;
    logic [BUD_W-1:0]    emit_used;
    logic                emit_last;
    logic                drop_ent;
    logic                evict_done;
    logic                insert_done;
    logic [EXT_W-1:0]    emit_key_ext;

    // field views and shared conditions
    assign rd_key      = rd_data[SIZE_W +: KEY_BITS];
    assign rd_size     = rd_data[SIZE_W-1:0];
    assign in_key_ext  = EXT_W'(i_req.key);
    assign in_key      = in_key_ext[KEY_BITS-1:0];
    assign in_acc      = i_req.valid && i_req.ready;
    assign can_emit    = !r_out_valid || o_rsp.ready;
    assign more_rd     = r_pos < r_cnt;
    assign found       = r_chk_valid && (rd_key == r_key);
    assign need_sum    = {1'b0, r_total} + (BUD_W+1)'(r_size);
    assign over_budget = need_sum > {1'b0, r_budget};
    assign ev_need     = ((r_cnt != '0) && over_budget) || (r_cnt == FULL);
    assign head_next   = (r_head == IDX_W'(ENTRIES - 1)) ? '0 : r_head + IDX_W'(1);

    // handshake ready lines
    assign i_req.ready = (r_state == bblc_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bblc_pkg::S_IDLE: begin
                if (in_acc) n_state = bblc_pkg::S_SEARCH;
            end
            bblc_pkg::S_SEARCH: begin
                if (found) begin
                    n_state = (r_cmd == bblc_pkg::CMD_INSERT) ? bblc_pkg::S_SHIFT
                                                              : bblc_pkg::S_HIT;
                end else if (!r_chk_valid) begin
                    n_state = (r_cmd == bblc_pkg::CMD_INSERT) ? bblc_pkg::S_EV_CHK
                                                              : bblc_pkg::S_MISS;
                end
            end
            bblc_pkg::S_HIT: begin
                if (can_emit) n_state = bblc_pkg::S_SHIFT;
            end
            bblc_pkg::S_MISS: begin
                if (can_emit) n_state = bblc_pkg::S_IDLE;
            end
            bblc_pkg::S_SHIFT: begin
                if (!more_rd) n_state = bblc_pkg::S_SH_END;
            end
            bblc_pkg::S_SH_END: begin
                n_state = (r_cmd == bblc_pkg::CMD_INSERT) ? bblc_pkg::S_EV_CHK
                                                          : bblc_pkg::S_IDLE;
            end
            bblc_pkg::S_EV_CHK: begin
                n_state = ev_need ? bblc_pkg::S_EV_OUT : bblc_pkg::S_INSERT;
            end
            bblc_pkg::S_EV_OUT: begin
                if (can_emit) n_state = bblc_pkg::S_EV_CHK;
            end
            bblc_pkg::S_INSERT: begin
                if (can_emit) n_state = bblc_pkg::S_IDLE;
            end
            default: n_state = bblc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        rd_en       = 1'b0;
        rd_pos      = r_pos[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_pos      = r_wr_pos;
        wr_data     = rd_data;
        emit        = 1'b0;
        emit_kind   = bblc_pkg::KIND_MISS;
        emit_key    = r_key;
        emit_size   = '0;
        emit_used   = r_total;
        emit_last   = 1'b1;
        drop_ent    = 1'b0;
        evict_done  = 1'b0;
        insert_done = 1'b0;
        unique case (r_state)
            bblc_pkg::S_IDLE: begin
                rd_en  = in_acc && (r_cnt != '0);
                rd_pos = '0;
            end
            bblc_pkg::S_SEARCH: begin
                rd_en = more_rd;
            end
            bblc_pkg::S_HIT: begin
                emit      = can_emit;
                emit_kind = bblc_pkg::KIND_HIT;
                emit_key  = r_ent_key;
                emit_size = r_ent_size;
            end
            bblc_pkg::S_MISS: begin
                emit = can_emit;
            end
            bblc_pkg::S_SHIFT: begin
                rd_en = more_rd;
                wr_en = r_pend;
            end
            bblc_pkg::S_SH_END: begin
                if (r_cmd == bblc_pkg::CMD_INSERT) begin
                    drop_ent = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_pos  = IDX_W'(r_cnt - ONE);
                    wr_data = {r_ent_key, r_ent_size};
                end
            end
            bblc_pkg::S_EV_CHK: begin
                rd_en  = ev_need;
                rd_pos = '0;
            end
            bblc_pkg::S_EV_OUT: begin
                emit       = can_emit;
                evict_done = can_emit;
                emit_kind  = bblc_pkg::KIND_EVICT;
                emit_key   = rd_key;
                emit_size  = rd_size;
                emit_used  = r_total - BUD_W'(rd_size);
                emit_last  = 1'b0;
            end
            bblc_pkg::S_INSERT: begin
                emit        = can_emit;
                insert_done = can_emit;
                wr_en       = can_emit;
                wr_pos      = r_cnt[IDX_W-1:0];
                wr_data     = {r_key, r_size};
                emit_kind   = bblc_pkg::KIND_INSERT;
                emit_size   = r_size;
                emit_used   = r_total + BUD_W'(r_size);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // state and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bblc_pkg::S_IDLE;
            r_budget    <= bblc_pkg::BUDGET_RESET;
            r_total     <= '0;
            r_cnt       <= '0;
            r_head      <= '0;
            r_chk_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_budget <= i_cfg.data;
            end
            if (r_state == bblc_pkg::S_SEARCH && found
                && r_cmd == bblc_pkg::CMD_INSERT) begin
                r_total <= r_total - BUD_W'(rd_size);
            end else if (evict_done) begin
                r_total <= emit_used;
            end else if (insert_done) begin
                r_total <= emit_used;
            end
            if (drop_ent || evict_done) begin
                r_cnt <= r_cnt - ONE;
            end else if (insert_done) begin
                r_cnt <= r_cnt + ONE;
            end
            if (evict_done) begin
                r_head <= head_next;
            end
            // search pipeline: address issued, then compare in the cycle after
            if (in_acc) begin
                r_chk_valid <= (r_cnt != '0);
            end else if (r_state == bblc_pkg::S_SEARCH) begin
                r_chk_valid <= more_rd && !found;
            end
            // shift pipeline: read a row, write it one place lower in the cycle after
            if (r_state == bblc_pkg::S_SHIFT) begin
                r_pend <= more_rd;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // request and scan payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_req.command;
            r_key     <= in_key;
            r_size    <= i_req.size;
            r_pos     <= ONE;
            r_chk_pos <= '0;
        end else if (r_state == bblc_pkg::S_SEARCH) begin
            if (found) begin
                r_ent_key  <= rd_key;
                r_ent_size <= rd_size;
                r_pos      <= r_chk_pos + ONE;
            end else begin
                r_pos     <= r_pos + CNT_W'(more_rd);
                r_chk_pos <= r_pos;
            end
        end else if (r_state == bblc_pkg::S_SHIFT) begin
            r_pos    <= r_pos + CNT_W'(more_rd);
            r_wr_pos <= IDX_W'(r_pos - ONE);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign emit_key_ext = EXT_W'(emit_key);

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_key  <= emit_key_ext[KEY_W-1:0];
            r_out_size <= emit_size;
            r_out_used <= emit_used;
            r_out_last <= emit_last;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.kind       = r_out_kind;
    assign o_rsp.entry_key  = r_out_key;
    assign o_rsp.entry_size = r_out_size;
    assign o_rsp.used_bytes = r_out_used;
    assign o_rsp.last       = r_out_last;

    // directory ring
    bblc_dir_ram #(
        .ENTRIES (ENTRIES),
        .WIDTH   (ENT_W)
    ) u_dir_ram (
        .i_clk     (i_clk),
        .i_head    (r_head),
        .i_rd_en   (rd_en),
        .i_rd_pos  (rd_pos),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_pos  (wr_pos),
        .i_wr_data (wr_data)
    );

    // a new result never overwrites one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || o_rsp.ready))
        else $error("result register overwritten");

    // an insert always finds a free row
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        insert_done |-> (r_cnt < FULL))
        else $error("insert with no free row");

    // an empty directory holds no bytes
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bblc_pkg::S_IDLE && r_cnt == '0) |-> (r_total == '0))
        else $error("byte total out of step with fill count");

    // the shift never reads and writes the same place
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_pos != wr_pos))
        else $error("read and write on the same row");

    // eviction leaves the fill count one lower
    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evict_done |=> (r_cnt == $past(r_cnt) - ONE))
        else $error("eviction did not release a row");

endmodule

// ----- sim/byte_budget_lru_cache_core_test.sv -----
`timescale 1ns / 100ps

module byte_budget_lru_cache_core_test;

    localparam int ENTRIES    = 32;
    localparam int KEY_BITS   = 16;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam int SETTLE_CYC = 2 * ENTRIES + 8;

    localparam logic [bblc_pkg::SIZE_W-1:0]   SIZE_MAX   = '1;
    localparam logic [bblc_pkg::BUDGET_W-1:0] BUDGET_MAX = '1;

    // one result beat as seen on o_rsp
    typedef struct packed {
        bblc_pkg::t_kind                 kind;
        logic [bblc_pkg::KEY_W-1:0]      key;
        logic [bblc_pkg::SIZE_W-1:0]     size;
        logic [bblc_pkg::BUDGET_W-1:0]   used;
        logic                            last;
    } t_cache_result;

    // directory model plus the queue of results still owed by the block
    class lru_directory_check;
        logic [bblc_pkg::BUDGET_W-1:0] budget;
        logic [bblc_pkg::KEY_W-1:0]    slot_key  [ENTRIES];
        logic [bblc_pkg::SIZE_W-1:0]   slot_size [ENTRIES];
        bit                            slot_live [ENTRIES];
        int                            slot_age  [ENTRIES];
        logic [bblc_pkg::BUDGET_W-1:0] bytes_used;
        int                            live_count;
        t_cache_result                 owed_results[$];
        int                            errors;

        function new();
            budget     = bblc_pkg::BUDGET_RESET;
            bytes_used = '0;
            live_count = 0;
            errors     = 0;
            foreach (slot_live[i]) begin
                slot_live[i] = 1'b0;
                slot_key[i]  = '0;
                slot_size[i] = '0;
                slot_age[i]  = 0;
            end
        endfunction

        function int find_key(logic [bblc_pkg::KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        // highest age is the least recently used entry
        function int find_oldest();
            int best;
            best = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && (best < 0 || slot_age[i] > slot_age[best]))
                    best = i;
            return best;
        endfunction

        // close the gap in the recency order and give back the bytes
        function void release_slot(int s);
            int r;
            r = slot_age[s];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && i != s && slot_age[i] > r)
                    slot_age[i]--;
            slot_live[s] = 1'b0;
            bytes_used   = bytes_used - bblc_pkg::BUDGET_W'(slot_size[s]);
            if (live_count > 0)
                live_count--;
        endfunction

        function void promote(int s);
            int r;
            r = slot_age[s];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i] && i != s && slot_age[i] < r)
                    slot_age[i]++;
            slot_age[s] = 0;
        endfunction

        function void owe_result(bblc_pkg::t_kind kind, logic [bblc_pkg::KEY_W-1:0] key,
                                 logic [bblc_pkg::SIZE_W-1:0] size, logic last);
            t_cache_result r;
            r.kind = kind;
            r.key  = key;
            r.size = size;
            r.used = bytes_used;
            r.last = last;
            owed_results = {owed_results, r};
        endfunction

        function void evict_oldest();
            int s;
            s = find_oldest();
            if (s < 0)
                return;
            release_slot(s);
            owe_result(bblc_pkg::KIND_EVICT, slot_key[s], slot_size[s], 1'b0);
        endfunction

        // work out every result one accepted request causes
        function void apply_request(logic cmd, logic [bblc_pkg::KEY_W-1:0] key,
                                    logic [bblc_pkg::SIZE_W-1:0] size);
            int s;
            s = find_key(key);
            if (cmd == bblc_pkg::CMD_LOOKUP) begin
                if (s >= 0) begin
                    promote(s);
                    owe_result(bblc_pkg::KIND_HIT, slot_key[s], slot_size[s], 1'b1);
                end else begin
                    owe_result(bblc_pkg::KIND_MISS, key, '0, 1'b1);
                end
                return;
            end

            // same key goes silently, then budget and slot evictions
            if (s >= 0)
                release_slot(s);
            while (live_count > 0 &&
                   ({1'b0, bytes_used} + (bblc_pkg::BUDGET_W + 1)'(size))
                   > {1'b0, budget})
                evict_oldest();
            if (live_count >= ENTRIES)
                evict_oldest();

            s = 0;
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (!slot_live[i])
                    s = i;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_live[i])
                    slot_age[i]++;
            slot_live[s] = 1'b1;
            slot_key[s]  = key;
            slot_size[s] = size;
            slot_age[s]  = 0;
            bytes_used   = bytes_used + bblc_pkg::BUDGET_W'(size);
            live_count++;
            owe_result(bblc_pkg::KIND_INSERT, key, size, 1'b1);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 60)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_cache_result got);
            t_cache_result want;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d key %h",
                                          got.kind, got.key));
                return;
            end
            want = owed_results.pop_front();
            if (got.kind != want.kind)
                report_mismatch($sformatf("kind %0d, wanted %0d (key %h)",
                                          got.kind, want.kind, want.key));
            if (got.key != want.key)
                report_mismatch($sformatf("entry_key %h, wanted %h", got.key, want.key));
            if (got.size != want.size)
                report_mismatch($sformatf("entry_size %h, wanted %h (key %h)",
                                          got.size, want.size, want.key));
            if (got.used != want.used)
                report_mismatch($sformatf("used_bytes %h, wanted %h (key %h)",
                                          got.used, want.used, want.key));
            if (got.last != want.last)
                report_mismatch($sformatf("last %b, wanted %b (key %h)",
                                          got.last, want.last, want.key));
        endtask

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bblc_req_if req_if ();
    bblc_rsp_if rsp_if ();
    bblc_cfg_if cfg_if ();

    lru_directory_check directory_check;

    bit no_idle;
    int rsp_hold_cycles;
    int cycle_count;

    byte_budget_lru_cache_core #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // keys mostly from a small pool so that hits and replacements happen
    function automatic logic [bblc_pkg::KEY_W-1:0] pick_key(int pool,
                                                            logic [bblc_pkg::KEY_W-1:0] salt);
        logic [bblc_pkg::KEY_W-1:0] idx;
        if ($urandom_range(0, 99) < 88) begin
            idx = bblc_pkg::KEY_W'($urandom_range(0, pool - 1));
            return (idx * 16'h9E37) ^ salt;
        end
        return bblc_pkg::KEY_W'($urandom);
    endfunction

    function automatic logic [bblc_pkg::SIZE_W-1:0] pick_size(int unsigned cap);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 12)
            return SIZE_MAX;
        if (r < 20)
            return bblc_pkg::SIZE_W'($urandom);
        return bblc_pkg::SIZE_W'($urandom_range(0, cap));
    endfunction

    // request beat, starting and ending on a falling edge
    task automatic send_request(logic cmd, logic [bblc_pkg::KEY_W-1:0] key,
                                logic [bblc_pkg::SIZE_W-1:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0)
            repeat (gap) @(negedge i_clk);
        req_if.valid   = 1'b1;
        req_if.command = cmd;
        req_if.key     = key;
        req_if.size    = size;
        do @(posedge i_clk); while (!req_if.ready);
        directory_check.apply_request(cmd, key, size);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic lookup(logic [bblc_pkg::KEY_W-1:0] key);
        send_request(bblc_pkg::CMD_LOOKUP, key, bblc_pkg::SIZE_W'($urandom));
    endtask

    task automatic insert(logic [bblc_pkg::KEY_W-1:0] key, logic [bblc_pkg::SIZE_W-1:0] size);
        send_request(bblc_pkg::CMD_INSERT, key, size);
    endtask

    // hold the request side until every owed result has been seen
    task automatic drain();
        while (directory_check.owed() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_budget(logic [bblc_pkg::BUDGET_W-1:0] value);
        drain();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        directory_check.budget = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic random_requests(int count, int pool, int insert_pct, int unsigned size_cap);
        logic [bblc_pkg::KEY_W-1:0] salt;
        salt = bblc_pkg::KEY_W'($urandom);
        for (int n = 0; n < count; n++)
            send_request(($urandom_range(0, 99) < insert_pct) ? bblc_pkg::CMD_INSERT
                                                              : bblc_pkg::CMD_LOOKUP,
                         pick_key(pool, salt), pick_size(size_cap));
    endtask

    // result side: random back-pressure, long hold when asked
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                stall_left      = rsp_hold_cycles;
                rsp_hold_cycles = 0;
            end
            if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready = 1'b1;
                stall_left   = pick_gap();
            end
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                directory_check.check_result('{kind: bblc_pkg::t_kind'(rsp_if.kind),
                                               key:  rsp_if.entry_key,
                                               size: rsp_if.entry_size,
                                               used: rsp_if.used_bytes,
                                               last: rsp_if.last});
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("byte_budget_lru_cache_core_test failed");
        $finish;
    end

    // stimulus
    initial begin
        directory_check = new();
        no_idle         = 1'b0;
        rsp_hold_cycles = 0;
        req_if.valid    = 1'b0;
        req_if.command  = bblc_pkg::CMD_LOOKUP;
        req_if.key      = '0;
        req_if.size     = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty cache, zero and full-scale sizes, hits and misses
        lookup(16'h0000);
        insert(16'h0000, '0);
        insert(16'hFFFF, SIZE_MAX);
        lookup(16'hFFFF);
        lookup(16'h0000);
        lookup(16'h1234);
        // over budget by one byte, then same key replaced
        insert(16'h0001, 28'd2);
        insert(16'h0000, 28'd5);
        lookup(16'h0000);

        // oversized entry clears the cache and still goes in
        write_budget(34'd100);
        insert(16'h00AA, 28'd200);
        insert(16'h00AB, 28'd50);
        insert(16'h00AC, 28'd40);

        // lowered budget only bites on the next insert
        write_budget(34'd60);
        lookup(16'h00AB);
        insert(16'h00AD, 28'd10);

        // zero budget with zero-byte entries
        write_budget('0);
        insert(16'h5555, '0);
        insert(16'hAAAA, '0);
        insert(16'h00FF, 28'd1);

        write_budget(BUDGET_MAX);
        insert(16'hFFFF, SIZE_MAX);
        insert(16'hFFFE, SIZE_MAX);
        lookup(16'h00FF);

        // budget never reached, so the slots fill and evict on count
        random_requests(90, 48, 85, SIZE_MAX);

        // small budget; result side held off at the start so the block backs up
        write_budget(34'd1000);
        rsp_hold_cycles = 300;
        random_requests(80, 24, 55, 400);

        // reset budget, no idling anywhere
        write_budget(bblc_pkg::BUDGET_RESET);
        no_idle = 1'b1;
        random_requests(50, 16, 60, SIZE_MAX);
        no_idle = 1'b0;

        // random budget, more stray keys
        write_budget({2'($urandom_range(0, 3)), 32'($urandom)});
        random_requests(80, 40, 50, 28'h1FFFFFF);

        // zero budget again, mostly zero-byte inserts
        write_budget('0);
        random_requests(20, 12, 70, 0);

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (directory_check.errors == 0 && directory_check.owed() == 0)
            $display("byte_budget_lru_cache_core_test passed");
        else
            $display("byte_budget_lru_cache_core_test failed");
        $finish;
    end

endmodule

// ----- byte_budget_lru_cache_core.f -----
rtl/core/bblc_pkg.sv
rtl/core/bblc_req_if.sv
rtl/core/bblc_rsp_if.sv
rtl/core/bblc_cfg_if.sv
rtl/core/bblc_dir_ram.sv
rtl/core/byte_budget_lru_cache_core.sv
sim/byte_budget_lru_cache_core_test.sv
